// ----- rtl/ppl_pkg.sv -----
package ppl_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_W = 128;
	localparam int DIV_W = 64;
	localparam int QUO_W = 63;

	localparam int FRONT_LAT = 5;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int GAP_LAT = 6;
	localparam int OUT_LAT = 4;
	localparam int LATENCY = FRONT_LAT + DIV_LAT + GAP_LAT + DIV_LAT + OUT_LAT;

	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] gap;
		logic               dxneg;
		logic               dyneg;
		logic               dir_ok;
		logic               negx;
		logic               negy;
	} ctx_t;

	typedef struct packed {
		logic signed [63:0] prx;
		logic signed [63:0] pry;
		logic               skip;
		logic               dir_ok;
		logic               negx;
		logic               negy;
	} gap_ctx_t;

	localparam int CTX_W = $bits(ctx_t);
	localparam int GAP_CTX_W = $bits(gap_ctx_t);

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_add = s[64] ? S64_MIN : S64_MAX;
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			sat_sub = s[64] ? S64_MIN : S64_MAX;
		end else begin
			sat_sub = s[63:0];
		end
	endfunction

	function automatic logic signed [63:0] sat_quot(input logic neg, input logic ovf,
			input logic [QUO_W-1:0] q);
		logic signed [63:0] m;
		m = {1'b0, q};
		if (ovf) begin
			sat_quot = neg ? S64_MIN : S64_MAX;
		end else begin
			sat_quot = neg ? -m : m;
		end
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

// ----- rtl/ppl_front.sv -----
module ppl_front #(
	parameter int FRAC_BITS = ppl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic signed [31:0]            origin_x,
	input  logic signed [31:0]            origin_y,
	input  logic signed [31:0]            dir_x,
	input  logic signed [31:0]            dir_y,
	input  logic signed [31:0]            gap,
	output logic                          out_valid,
	output logic [ppl_pkg::NUM_W-1:0]     num_x,
	output logic [ppl_pkg::NUM_W-1:0]     num_y,
	output logic [ppl_pkg::DIV_W-1:0]     den,
	output ppl_pkg::ctx_t                 ctx
);

	localparam int ISHIFT = 32 - FRAC_BITS;

	logic signed [32:0] vx, vy;
	logic [32:0] nvx, nvy;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0] adx_s1, ady_s1, avx_s1, avy_s1;
	logic n1_s1, n2_s1;
	ppl_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	ppl_pkg::ctx_t ctx3_c, ctx4_c;

	logic [31:0] adx_s2, ady_s2;
	logic [63:0] ddx_s2, ddy_s2, m1_s2, m2_s2;
	logic n1_s2, n2_s2;

	logic [31:0] adx_s3, ady_s3;
	logic [63:0] den_s3, nmag_s3;
	logic nneg_s3;
	logic [63:0] den_c, nmag_c;
	logic nneg_c;

	logic [63:0] den_s4, pxl_s4, pxh_s4, pyl_s4, pyh_s4;
	logic [95:0] prod_x, prod_y;

	logic [63:0] den_s5;
	logic [ppl_pkg::NUM_W-1:0] num_x_s5, num_y_s5;

	always_comb begin
		vx = {point_x[31], point_x} - {origin_x[31], origin_x};
		vy = {point_y[31], point_y} - {origin_y[31], origin_y};
		nvx = vx[32] ? (~vx + 33'd1) : vx;
		nvy = vy[32] ? (~vy + 33'd1) : vy;
	end

	always_comb begin
		den_c = ddx_s2 + ddy_s2;
		if (n1_s2 == n2_s2) begin
			nmag_c = m1_s2 + m2_s2;
			nneg_c = n1_s2;
		end else if (m1_s2 >= m2_s2) begin
			nmag_c = m1_s2 - m2_s2;
			nneg_c = n1_s2;
		end else begin
			nmag_c = m2_s2 - m1_s2;
			nneg_c = n2_s2;
		end
		if (nmag_c == 64'd0) begin
			nneg_c = 1'b0;
		end
	end

	always_comb begin
		ctx3_c = ctx_s2;
		ctx3_c.dir_ok = (den_c != 64'd0);
		ctx4_c = ctx_s3;
		ctx4_c.negx = nneg_s3 ^ ctx_s3.dxneg;
		ctx4_c.negy = nneg_s3 ^ ctx_s3.dyneg;
	end

	always_comb begin
		prod_x = 96'(pxl_s4) + {pxh_s4, 32'd0};
		prod_y = 96'(pyl_s4) + {pyh_s4, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		adx_s1 <= dir_x[31] ? (~dir_x + 32'd1) : dir_x;
		ady_s1 <= dir_y[31] ? (~dir_y + 32'd1) : dir_y;
		avx_s1 <= nvx[31:0];
		avy_s1 <= nvy[31:0];
		n1_s1 <= vx[32] ^ dir_x[31];
		n2_s1 <= vy[32] ^ dir_y[31];
		ctx_s1.px <= point_x;
		ctx_s1.py <= point_y;
		ctx_s1.ox <= origin_x;
		ctx_s1.oy <= origin_y;
		ctx_s1.gap <= gap;
		ctx_s1.dxneg <= dir_x[31];
		ctx_s1.dyneg <= dir_y[31];
		ctx_s1.dir_ok <= 1'b0;
		ctx_s1.negx <= 1'b0;
		ctx_s1.negy <= 1'b0;

		adx_s2 <= adx_s1;
		ady_s2 <= ady_s1;
		ddx_s2 <= 64'(adx_s1) * 64'(adx_s1);
		ddy_s2 <= 64'(ady_s1) * 64'(ady_s1);
		m1_s2 <= 64'(avx_s1) * 64'(adx_s1);
		m2_s2 <= 64'(avy_s1) * 64'(ady_s1);
		n1_s2 <= n1_s1;
		n2_s2 <= n2_s1;
		ctx_s2 <= ctx_s1;

		adx_s3 <= adx_s2;
		ady_s3 <= ady_s2;
		den_s3 <= den_c;
		nmag_s3 <= nmag_c;
		nneg_s3 <= nneg_c;
		ctx_s3 <= ctx3_c;

		den_s4 <= den_s3;
		pxl_s4 <= 64'(adx_s3) * 64'(nmag_s3[31:0]);
		pxh_s4 <= 64'(adx_s3) * 64'(nmag_s3[63:32]);
		pyl_s4 <= 64'(ady_s3) * 64'(nmag_s3[31:0]);
		pyh_s4 <= 64'(ady_s3) * 64'(nmag_s3[63:32]);
		ctx_s4 <= ctx4_c;

		den_s5 <= den_s4;
		num_x_s5 <= ppl_pkg::NUM_W'(prod_x) << ISHIFT;
		num_y_s5 <= ppl_pkg::NUM_W'(prod_y) << ISHIFT;
		ctx_s5 <= ctx_s4;
	end

	assign out_valid = vld_s5;
	assign num_x = num_x_s5;
	assign num_y = num_y_s5;
	assign den = den_s5;
	assign ctx = ctx_s5;

endmodule

// ----- rtl/ppl_div.sv -----
module ppl_div #(
	parameter int TAG_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ppl_pkg::NUM_W-1:0]     num_x,
	input  logic [ppl_pkg::NUM_W-1:0]     num_y,
	input  logic [ppl_pkg::DIV_W-1:0]     den,
	input  logic [TAG_W-1:0]              in_tag,
	output logic                          out_valid,
	output logic [ppl_pkg::QUO_W-1:0]     quo_x,
	output logic [ppl_pkg::QUO_W-1:0]     quo_y,
	output logic                          ovf_x,
	output logic                          ovf_y,
	output logic [TAG_W-1:0]              out_tag
);

	localparam int NUM_W = ppl_pkg::NUM_W;
	localparam int DIV_W = ppl_pkg::DIV_W;
	localparam int QUO_W = ppl_pkg::QUO_W;

	logic             vld_s   [QUO_W+1];
	logic [DIV_W-1:0] den_s   [QUO_W+1];
	logic [DIV_W-1:0] rem_x_s [QUO_W+1];
	logic [DIV_W-1:0] rem_y_s [QUO_W+1];
	logic [QUO_W-1:0] low_x_s [QUO_W+1];
	logic [QUO_W-1:0] low_y_s [QUO_W+1];
	logic [QUO_W-1:0] quo_x_s [QUO_W+1];
	logic [QUO_W-1:0] quo_y_s [QUO_W+1];
	logic             ovf_x_s [QUO_W+1];
	logic             ovf_y_s [QUO_W+1];
	logic [TAG_W-1:0] tag_s   [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0] <= den;
		rem_x_s[0] <= num_x[NUM_W-2:QUO_W];
		rem_y_s[0] <= num_y[NUM_W-2:QUO_W];
		low_x_s[0] <= num_x[QUO_W-1:0];
		low_y_s[0] <= num_y[QUO_W-1:0];
		quo_x_s[0] <= '0;
		quo_y_s[0] <= '0;
		ovf_x_s[0] <= (num_x[NUM_W-1:QUO_W] >= {1'b0, den});
		ovf_y_s[0] <= (num_y[NUM_W-1:QUO_W] >= {1'b0, den});
		tag_s[0] <= in_tag;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DIV_W:0] try_x, try_y, sub_x, sub_y;
		logic ge_x, ge_y;

		always_comb begin
			try_x = {rem_x_s[k], low_x_s[k][QUO_W-1]};
			try_y = {rem_y_s[k], low_y_s[k][QUO_W-1]};
			sub_x = try_x - {1'b0, den_s[k]};
			sub_y = try_y - {1'b0, den_s[k]};
			ge_x = (try_x >= {1'b0, den_s[k]});
			ge_y = (try_y >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			rem_x_s[k+1] <= ge_x ? sub_x[DIV_W-1:0] : try_x[DIV_W-1:0];
			rem_y_s[k+1] <= ge_y ? sub_y[DIV_W-1:0] : try_y[DIV_W-1:0];
			low_x_s[k+1] <= {low_x_s[k][QUO_W-2:0], 1'b0};
			low_y_s[k+1] <= {low_y_s[k][QUO_W-2:0], 1'b0};
			quo_x_s[k+1] <= {quo_x_s[k][QUO_W-2:0], ge_x};
			quo_y_s[k+1] <= {quo_y_s[k][QUO_W-2:0], ge_y};
			ovf_x_s[k+1] <= ovf_x_s[k];
			ovf_y_s[k+1] <= ovf_y_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo_x = quo_x_s[QUO_W];
	assign quo_y = quo_y_s[QUO_W];
	assign ovf_x = ovf_x_s[QUO_W];
	assign ovf_y = ovf_y_s[QUO_W];
	assign out_tag = tag_s[QUO_W];

endmodule

// ----- rtl/ppl_gap.sv -----
module ppl_gap #(
	parameter int FRAC_BITS = ppl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ppl_pkg::QUO_W-1:0]     quo_x,
	input  logic [ppl_pkg::QUO_W-1:0]     quo_y,
	input  logic                          ovf_x,
	input  logic                          ovf_y,
	input  ppl_pkg::ctx_t                 ctx,
	output logic                          out_valid,
	output logic [ppl_pkg::NUM_W-1:0]     num_x,
	output logic [ppl_pkg::NUM_W-1:0]     num_y,
	output logic [ppl_pkg::DIV_W-1:0]     dist_len,
	output ppl_pkg::gap_ctx_t             gctx
);

	localparam int ISHIFT = 32 - FRAC_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	ppl_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic signed [63:0] sx_s1, sy_s1;
	logic signed [63:0] prx_s2, pry_s2, prx_s3, pry_s3, prx_s4, pry_s4, prx_s5, pry_s5;
	logic signed [63:0] fx_s3, fy_s3;
	logic [63:0] ax_s4, ay_s4;
	logic fxneg_s4, fyneg_s4, fxneg_s5, fyneg_s5;
	logic [31:0] ag_s4;
	logic gneg_s4, gneg_s5;
	logic [63:0] dist_s5, axl_s5, axh_s5, ayl_s5, ayh_s5;
	logic signed [63:0] ox_w, oy_w, px_w, py_w;
	logic [63:0] hiv, lov;
	logic [95:0] prod_x, prod_y;

	logic [ppl_pkg::NUM_W-1:0] num_x_s6, num_y_s6;
	logic [63:0] dist_s6;
	ppl_pkg::gap_ctx_t gctx_s6;

	always_comb begin
		ox_w = {{32{ctx_s1.ox[31]}}, ctx_s1.ox} << ISHIFT;
		oy_w = {{32{ctx_s1.oy[31]}}, ctx_s1.oy} << ISHIFT;
		px_w = {{32{ctx_s2.px[31]}}, ctx_s2.px} << ISHIFT;
		py_w = {{32{ctx_s2.py[31]}}, ctx_s2.py} << ISHIFT;
		hiv = (ax_s4 < ay_s4) ? ay_s4 : ax_s4;
		lov = (ax_s4 < ay_s4) ? ax_s4 : ay_s4;
		prod_x = 96'(axl_s5) + {axh_s5, 32'd0};
		prod_y = 96'(ayl_s5) + {ayh_s5, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= ppl_pkg::sat_quot(ctx.negx, ovf_x, quo_x);
		sy_s1 <= ppl_pkg::sat_quot(ctx.negy, ovf_y, quo_y);
		ctx_s1 <= ctx;

		prx_s2 <= ppl_pkg::sat_add(ox_w, sx_s1);
		pry_s2 <= ppl_pkg::sat_add(oy_w, sy_s1);
		ctx_s2 <= ctx_s1;

		fx_s3 <= ppl_pkg::sat_sub(prx_s2, px_w);
		fy_s3 <= ppl_pkg::sat_sub(pry_s2, py_w);
		prx_s3 <= prx_s2;
		pry_s3 <= pry_s2;
		ctx_s3 <= ctx_s2;

		ax_s4 <= ppl_pkg::mag64(fx_s3);
		ay_s4 <= ppl_pkg::mag64(fy_s3);
		fxneg_s4 <= fx_s3[63];
		fyneg_s4 <= fy_s3[63];
		ag_s4 <= ctx_s3.gap[31] ? (~ctx_s3.gap + 32'd1) : ctx_s3.gap;
		gneg_s4 <= ctx_s3.gap[31];
		prx_s4 <= prx_s3;
		pry_s4 <= pry_s3;
		ctx_s4 <= ctx_s3;

		dist_s5 <= hiv + {1'b0, lov[63:1]};
		axl_s5 <= 64'(ax_s4[31:0]) * 64'(ag_s4);
		axh_s5 <= 64'(ax_s4[63:32]) * 64'(ag_s4);
		ayl_s5 <= 64'(ay_s4[31:0]) * 64'(ag_s4);
		ayh_s5 <= 64'(ay_s4[63:32]) * 64'(ag_s4);
		fxneg_s5 <= fxneg_s4;
		fyneg_s5 <= fyneg_s4;
		gneg_s5 <= gneg_s4;
		prx_s5 <= prx_s4;
		pry_s5 <= pry_s4;
		ctx_s5 <= ctx_s4;

		num_x_s6 <= ppl_pkg::NUM_W'(prod_x) << ISHIFT;
		num_y_s6 <= ppl_pkg::NUM_W'(prod_y) << ISHIFT;
		dist_s6 <= dist_s5;
		gctx_s6.prx <= prx_s5;
		gctx_s6.pry <= pry_s5;
		gctx_s6.skip <= (ctx_s5.gap == 32'sd0) || (dist_s5 == 64'd0);
		gctx_s6.dir_ok <= ctx_s5.dir_ok;
		gctx_s6.negx <= fxneg_s5 ^ gneg_s5;
		gctx_s6.negy <= fyneg_s5 ^ gneg_s5;
	end

	assign out_valid = vld_s6;
	assign num_x = num_x_s6;
	assign num_y = num_y_s6;
	assign dist_len = dist_s6;
	assign gctx = gctx_s6;

endmodule

// ----- rtl/ppl_out.sv -----
module ppl_out #(
	parameter int FRAC_BITS = ppl_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ppl_pkg::QUO_W-1:0]     quo_x,
	input  logic [ppl_pkg::QUO_W-1:0]     quo_y,
	input  logic                          ovf_x,
	input  logic                          ovf_y,
	input  ppl_pkg::gap_ctx_t             gctx,
	output logic                          done,
	output logic signed [31:0]            proj_x,
	output logic signed [31:0]            proj_y,
	output logic                          valid_res
);

	localparam int ISHIFT = 32 - FRAC_BITS;
	localparam logic [63:0] HALF = 64'd1 << (ISHIFT - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [63:0] sx_s1, sy_s1, rx_s2, ry_s2;
	ppl_pkg::gap_ctx_t gctx_s1;
	logic ok_s2, ok_s3;
	logic [63:0] mx_s3, my_s3;
	logic nx_s3, ny_s3;
	logic [63:0] rndx, rndy;
	logic [31:0] ox_c, oy_c;

	logic signed [31:0] proj_x_s4, proj_y_s4;
	logic valid_s4;

	function automatic logic [31:0] clamp_out(input logic neg, input logic [63:0] r);
		if (!neg) begin
			clamp_out = (r > 64'h7fff_ffff) ? 32'h7fff_ffff : r[31:0];
		end else begin
			clamp_out = (r > 64'h8000_0000) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
		end
	endfunction

	always_comb begin
		rndx = (mx_s3 + HALF) >> ISHIFT;
		rndy = (my_s3 + HALF) >> ISHIFT;
		ox_c = clamp_out(nx_s3, rndx);
		oy_c = clamp_out(ny_s3, rndy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= ppl_pkg::sat_quot(gctx.negx, ovf_x, quo_x);
		sy_s1 <= ppl_pkg::sat_quot(gctx.negy, ovf_y, quo_y);
		gctx_s1 <= gctx;

		rx_s2 <= gctx_s1.skip ? gctx_s1.prx : ppl_pkg::sat_sub(gctx_s1.prx, sx_s1);
		ry_s2 <= gctx_s1.skip ? gctx_s1.pry : ppl_pkg::sat_sub(gctx_s1.pry, sy_s1);
		ok_s2 <= gctx_s1.dir_ok;

		mx_s3 <= ppl_pkg::mag64(rx_s2);
		my_s3 <= ppl_pkg::mag64(ry_s2);
		nx_s3 <= rx_s2[63];
		ny_s3 <= ry_s2[63];
		ok_s3 <= ok_s2;

		proj_x_s4 <= ok_s3 ? ox_c : 32'sd0;
		proj_y_s4 <= ok_s3 ? oy_c : 32'sd0;
		valid_s4 <= ok_s3;
	end

	assign done = vld_s4;
	assign proj_x = proj_x_s4;
	assign proj_y = proj_y_s4;
	assign valid_res = valid_s4;

endmodule

// ----- rtl/project_point_on_line_gap_top.sv -----
// point-on-line projection with gap, fully pipelined: one request is taken every clock
// and its result appears on proj_x/proj_y/valid_res with done high once it has passed
// the front, projection divider, gap, gap divider and output blocks; busy stays low since
// the pipeline never stalls and the receiver must take each result in its cycle; the two
// 63-stage quotient pipelines produce one quotient bit per stage
module project_point_on_line_gap_top #(
	parameter int FRAC_BITS = ppl_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] gap,
	output logic               done,
	output logic signed [31:0] proj_x,
	output logic signed [31:0] proj_y,
	output logic               valid_res
);

	logic f_valid;
	logic [ppl_pkg::NUM_W-1:0] f_num_x, f_num_y;
	logic [ppl_pkg::DIV_W-1:0] f_den;
	ppl_pkg::ctx_t f_ctx, d1_ctx;

	logic d1_valid, d1_ovf_x, d1_ovf_y;
	logic [ppl_pkg::QUO_W-1:0] d1_quo_x, d1_quo_y;
	logic [ppl_pkg::CTX_W-1:0] d1_tag;

	logic g_valid;
	logic [ppl_pkg::NUM_W-1:0] g_num_x, g_num_y;
	logic [ppl_pkg::DIV_W-1:0] g_dist;
	ppl_pkg::gap_ctx_t g_ctx, d2_ctx;

	logic d2_valid, d2_ovf_x, d2_ovf_y;
	logic [ppl_pkg::QUO_W-1:0] d2_quo_x, d2_quo_y;
	logic [ppl_pkg::GAP_CTX_W-1:0] d2_tag;

	assign busy = 1'b0;
	assign d1_ctx = ppl_pkg::ctx_t'(d1_tag);
	assign d2_ctx = ppl_pkg::gap_ctx_t'(d2_tag);

	ppl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.point_x  (point_x),
		.point_y  (point_y),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.gap      (gap),
		.out_valid(f_valid),
		.num_x    (f_num_x),
		.num_y    (f_num_y),
		.den      (f_den),
		.ctx      (f_ctx)
	);

	ppl_div #(.TAG_W(ppl_pkg::CTX_W)) u_div_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.num_x    (f_num_x),
		.num_y    (f_num_y),
		.den      (f_den),
		.in_tag   (f_ctx),
		.out_valid(d1_valid),
		.quo_x    (d1_quo_x),
		.quo_y    (d1_quo_y),
		.ovf_x    (d1_ovf_x),
		.ovf_y    (d1_ovf_y),
		.out_tag  (d1_tag)
	);

	ppl_gap #(.FRAC_BITS(FRAC_BITS)) u_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d1_valid),
		.quo_x    (d1_quo_x),
		.quo_y    (d1_quo_y),
		.ovf_x    (d1_ovf_x),
		.ovf_y    (d1_ovf_y),
		.ctx      (d1_ctx),
		.out_valid(g_valid),
		.num_x    (g_num_x),
		.num_y    (g_num_y),
		.dist_len (g_dist),
		.gctx     (g_ctx)
	);

	ppl_div #(.TAG_W(ppl_pkg::GAP_CTX_W)) u_div_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (g_valid),
		.num_x    (g_num_x),
		.num_y    (g_num_y),
		.den      (g_dist),
		.in_tag   (g_ctx),
		.out_valid(d2_valid),
		.quo_x    (d2_quo_x),
		.quo_y    (d2_quo_y),
		.ovf_x    (d2_ovf_x),
		.ovf_y    (d2_ovf_y),
		.out_tag  (d2_tag)
	);

	ppl_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d2_valid),
		.quo_x    (d2_quo_x),
		.quo_y    (d2_quo_y),
		.ovf_x    (d2_ovf_x),
		.ovf_y    (d2_ovf_y),
		.gctx     (d2_ctx),
		.done     (done),
		.proj_x   (proj_x),
		.proj_y   (proj_y),
		.valid_res(valid_res)
	);

endmodule

// ----- rtl/ppl_chk.sv -----
module ppl_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [31:0] dir_x,
	input logic signed [31:0] dir_y,
	input logic               done,
	input logic signed [31:0] proj_x,
	input logic signed [31:0] proj_y,
	input logic               valid_res
);

	localparam int LAT = ppl_pkg::LATENCY;

	a_request_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without request");

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && dir_x == 32'sd0 && dir_y == 32'sd0) |-> ##LAT (done && !valid_res))
		else $error("zero direction gave a valid result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (proj_x == 32'sd0 && proj_y == 32'sd0))
		else $error("invalid result with nonzero projection");

endmodule

bind project_point_on_line_gap_top ppl_chk u_chk (.*);
